// File: hdl/v3au_pkg.sv
package v3au_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int PW        = 2 * DW;
  localparam int WW        = PW + 2;
  localparam int QW        = DW + FRAC_BITS;
  localparam int SQ_STEPS  = DW;
  localparam int MODE_W    = 3;
  localparam int LANES     = 3;
  localparam int IN_TDATA_W  = 7 * DW;
  localparam int OUT_TDATA_W = 4 * DW;

  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DOT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CROSS = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LEN   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NORM  = 3'd7;

  localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [WW-1:0] WIDE_MAX = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WW-1:0] WIDE_MIN = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [WW-1:0] HALF_LSB = {{(WW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  typedef logic signed [DW-1:0] word_t;
  typedef logic [LANES-1:0][DW-1:0] vec_t;
  typedef logic [LANES-1:0][QW-1:0] quo_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    vec_t              a;
    word_t             f;
    vec_t              v;
    word_t             sc;
    logic              sat;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          sat;
  } sat_t;

  // Round to nearest, ties up, dropping the fraction bits.
  function automatic logic signed [WW-1:0] rnd_frac(input logic signed [WW-1:0] w);
    logic signed [WW-1:0] t;
    t = w + HALF_LSB;
    return t >>> FRAC_BITS;
  endfunction

  function automatic sat_t sat_word(input logic signed [WW-1:0] v);
    sat_t r;
    if (v > WIDE_MAX) begin
      r.val = WORD_MAX;
      r.sat = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.val = WORD_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/v3au_front.sv
module v3au_front
  import v3au_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [MODE_W-1:0] mode_i,
  input  vec_t              a_i,
  input  vec_t              b_i,
  input  word_t             f_i,
  output logic              vld_o,
  output item_t             item_o,
  output logic [PW-1:0]     sumsq_o
);

  // stage A: operands
  logic              vld_a_q;
  logic [MODE_W-1:0] mode_a_q;
  vec_t              a_a_q, b_a_q;
  word_t             f_a_q;

  // stage B: products and add/sub
  logic                   vld_b_q;
  logic [MODE_W-1:0]      mode_b_q;
  vec_t                   a_b_q;
  word_t                  f_b_q;
  logic signed [PW-1:0]   p_d [6];
  logic signed [PW-1:0]   p_b_q [6];
  logic signed [DW:0]     e_d [LANES];
  logic signed [DW:0]     e_b_q [LANES];
  logic [DW-1:0]          lhs [6];
  logic [DW-1:0]          rhs [6];
  logic                   is_scale, is_cross, is_sq;

  // stage C: wide sums
  logic                   vld_c_q;
  logic [MODE_W-1:0]      mode_c_q;
  vec_t                   a_c_q;
  word_t                  f_c_q;
  logic signed [WW-1:0]   w_d [LANES];
  logic signed [WW-1:0]   w_c_q [LANES];
  logic signed [DW:0]     e_c_q [LANES];
  logic [PW-1:0]          s_d, s_c_q;

  // stage D: round and clamp
  sat_t                   rr [LANES];
  sat_t                   ra [LANES];
  item_t                  item_d;

  always_comb begin
    is_scale = (mode_a_q == MODE_SCALE);
    is_cross = (mode_a_q == MODE_CROSS);
    is_sq    = (mode_a_q == MODE_LEN) || (mode_a_q == MODE_NORM);
    lhs[0] = is_cross ? a_a_q[1] : a_a_q[0];
    rhs[0] = is_scale ? f_a_q : (is_cross ? b_a_q[2] : (is_sq ? a_a_q[0] : b_a_q[0]));
    lhs[1] = is_cross ? a_a_q[2] : a_a_q[1];
    rhs[1] = is_scale ? f_a_q : (is_cross ? b_a_q[1] : (is_sq ? a_a_q[1] : b_a_q[1]));
    lhs[2] = a_a_q[2];
    rhs[2] = is_scale ? f_a_q : (is_cross ? b_a_q[0] : (is_sq ? a_a_q[2] : b_a_q[2]));
    lhs[3] = a_a_q[0];
    rhs[3] = b_a_q[2];
    lhs[4] = a_a_q[0];
    rhs[4] = b_a_q[1];
    lhs[5] = a_a_q[1];
    rhs[5] = b_a_q[0];
    for (int i = 0; i < 6; i++) begin
      p_d[i] = $signed(lhs[i]) * $signed(rhs[i]);
    end
    for (int i = 0; i < LANES; i++) begin
      if (mode_a_q == MODE_SUB) begin
        e_d[i] = $signed({a_a_q[i][DW-1], a_a_q[i]}) - $signed({b_a_q[i][DW-1], b_a_q[i]});
      end else begin
        e_d[i] = $signed({a_a_q[i][DW-1], a_a_q[i]}) + $signed({b_a_q[i][DW-1], b_a_q[i]});
      end
    end
  end

  always_comb begin
    if (mode_b_q == MODE_DOT) begin
      w_d[0] = WW'(p_b_q[0]) + WW'(p_b_q[1]) + WW'(p_b_q[2]);
    end else if (mode_b_q == MODE_CROSS) begin
      w_d[0] = WW'(p_b_q[0]) - WW'(p_b_q[1]);
    end else begin
      w_d[0] = WW'(p_b_q[0]);
    end
    w_d[1] = (mode_b_q == MODE_CROSS) ? WW'(p_b_q[2]) - WW'(p_b_q[3]) : WW'(p_b_q[1]);
    w_d[2] = (mode_b_q == MODE_CROSS) ? WW'(p_b_q[4]) - WW'(p_b_q[5]) : WW'(p_b_q[2]);
    // squares are never negative, so the plain sum fits
    s_d = $unsigned(p_b_q[0]) + $unsigned(p_b_q[1]) + $unsigned(p_b_q[2]);
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rr[i] = sat_word(rnd_frac(w_c_q[i]));
      ra[i] = sat_word(WW'(e_c_q[i]));
    end
    item_d      = '0;
    item_d.mode = mode_c_q;
    item_d.a    = a_c_q;
    item_d.f    = f_c_q;
    unique case (mode_c_q)
      MODE_ADD, MODE_SUB: begin
        for (int i = 0; i < LANES; i++) begin
          item_d.v[i] = ra[i].val;
        end
        item_d.sat = ra[0].sat | ra[1].sat | ra[2].sat;
      end
      MODE_SCALE, MODE_CROSS: begin
        for (int i = 0; i < LANES; i++) begin
          item_d.v[i] = rr[i].val;
        end
        item_d.sat = rr[0].sat | rr[1].sat | rr[2].sat;
      end
      MODE_DOT: begin
        item_d.sc  = rr[0].val;
        item_d.sat = rr[0].sat;
      end
      MODE_DIV, MODE_LEN, MODE_NORM: begin
        item_d.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_o   <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_o   <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_a_q <= mode_i;
      a_a_q    <= a_i;
      b_a_q    <= b_i;
      f_a_q    <= f_i;
      mode_b_q <= mode_a_q;
      a_b_q    <= a_a_q;
      f_b_q    <= f_a_q;
      p_b_q    <= p_d;
      e_b_q    <= e_d;
      mode_c_q <= mode_b_q;
      a_c_q    <= a_b_q;
      f_c_q    <= f_b_q;
      w_c_q    <= w_d;
      e_c_q    <= e_b_q;
      s_c_q    <= s_d;
      item_o   <= item_d;
      sumsq_o  <= s_c_q;
    end
  end

endmodule

// File: hdl/v3au_sqrt.sv
module v3au_sqrt
  import v3au_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  item_t         item_i,
  input  logic [PW-1:0] sumsq_i,
  output logic          vld_o,
  output item_t         item_o,
  output logic [DW-1:0] len_o
);

  typedef struct packed {
    item_t         itm;
    logic [PW-1:0] x;
    logic [PW-1:0] r;
  } sq_t;

  sq_t  st_q  [SQ_STEPS];
  logic vld_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [PW:0] BIT = {{PW{1'b0}}, 1'b1} << (2 * (SQ_STEPS - 1 - k));
    sq_t         sin;
    logic        vin;
    logic [PW:0] trial;
    logic        ge;

    if (k == 0) begin : g_head
      always_comb begin
        sin.itm = item_i;
        sin.x   = sumsq_i;
        sin.r   = '0;
      end
      assign vin = vld_i;
    end else begin : g_link
      assign sin = st_q[k-1];
      assign vin = vld_q[k-1];
    end

    always_comb begin
      trial = {1'b0, sin.r} + BIT;
      ge    = ({1'b0, sin.x} >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k].itm <= sin.itm;
        st_q[k].x   <= ge ? sin.x - trial[PW-1:0] : sin.x;
        st_q[k].r   <= ge ? (sin.r >> 1) + BIT[PW-1:0] : (sin.r >> 1);
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o <= st_q[SQ_STEPS-1].itm;
      len_o  <= st_q[SQ_STEPS-1].r[DW-1:0]
                + DW'(st_q[SQ_STEPS-1].x > st_q[SQ_STEPS-1].r);
    end
  end

endmodule

// File: hdl/v3au_div.sv
module v3au_div
  import v3au_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  item_t         item_i,
  input  logic [DW-1:0] len_i,
  output logic          vld_o,
  output item_t         item_o,
  output logic [DW-1:0] len_o,
  output quo_t          quo_o,
  output logic [2:0]    neg_o
);

  typedef struct packed {
    item_t          itm;
    logic [DW-1:0]  len;
    logic [DW-1:0]  dvs;
    logic [2:0]     neg;
    vec_t           rem;
    quo_t           w;
  } dv_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  dv_t  st_q  [QW+1];
  logic vld_q [QW+1];
  dv_t  st_d;

  // setup: divisor and unsigned dividends with the fraction shift built in
  always_comb begin
    st_d.itm = item_i;
    st_d.len = len_i;
    st_d.dvs = (item_i.mode == MODE_DIV) ? mag(item_i.f) : len_i;
    st_d.rem = '0;
    for (int l = 0; l < LANES; l++) begin
      st_d.neg[l] = item_i.a[l][DW-1] ^ ((item_i.mode == MODE_DIV) & item_i.f[DW-1]);
      st_d.w[l]   = {mag(item_i.a[l]), {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st_d;
    end
  end

  // one quotient bit per lane per stage; the dividend shifts out as quotient shifts in
  for (genvar k = 1; k <= QW; k++) begin : g_step
    dv_t        nx;
    logic [DW:0] t [LANES];
    logic [DW:0] diff [LANES];
    logic [2:0]  ge;

    always_comb begin
      nx = st_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        t[l]      = {st_q[k-1].rem[l], st_q[k-1].w[l][QW-1]};
        diff[l]   = t[l] - {1'b0, st_q[k-1].dvs};
        ge[l]     = (t[l] >= {1'b0, st_q[k-1].dvs});
        nx.rem[l] = ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
        nx.w[l]   = {st_q[k-1].w[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nx;
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign item_o = st_q[QW].itm;
  assign len_o  = st_q[QW].len;
  assign quo_o  = st_q[QW].w;
  assign neg_o  = st_q[QW].neg;

endmodule

// File: hdl/vector3_arith_unit_top.sv
// 3D vector arithmetic unit on signed Q16.16 operands.
// Input channel (s_axis): one transaction carries vectors A and B, a scalar
// factor and the operation mode in tuser. Output channel (m_axis): one
// transaction per input with the vector result, the scalar result and the
// flags div_by_zero and saturated in tuser.
// Modes: add, sub, scale, divide, dot, cross, length, normalize. Products
// round to nearest (ties up); quotients truncate toward zero; every result
// clamps to 32 bits and raises saturated when clamped.
// Pipe, the same for every mode: the front stages, the 32-step square root,
// the (32 + FRAC_BITS)-step restoring divider (FRAC_BITS is 16 for Q16.16)
// and the output register, in that order.
// Throughput: one transaction per cycle while the pipe is not stalled.
// Reset: clears all valid bits, the output is empty afterward.
// Stall: when m_axis_tready is low with a result waiting, the whole pipe
// holds and s_axis_tready drops; nothing is lost or repeated.
module vector3_arith_unit_top
  import v3au_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // ax, ay, az, bx, by, bz, factor (32 bits each, from bit 0 up)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // rx, ry, rz, scalar_result (32 bits each, from bit 0 up)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // div_by_zero, saturated (from bit 0 up)
  output logic [1:0]             m_axis_tuser
);

  localparam logic [QW-1:0] QPOS_MAX = QW'(WORD_MAX);
  localparam logic [QW-1:0] QNEG_MAX = QW'(WORD_MAX) + 1'b1;

  logic          en;
  logic          out_vld_q;
  vec_t          a_in, b_in;

  logic          fr_vld;
  item_t         fr_item;
  logic [PW-1:0] fr_sumsq;
  logic          sq_vld;
  item_t         sq_item;
  logic [DW-1:0] sq_len;
  logic          dv_vld;
  item_t         dv_item;
  logic [DW-1:0] dv_len;
  quo_t          dv_quo;
  logic [2:0]    dv_neg;

  vec_t          qv;
  logic [2:0]    qsat;
  logic [DW-1:0] qneg [LANES];
  vec_t          rv_d;
  logic [DW-1:0] sc_d;
  logic          dz_d, sat_d;
  vec_t          rv_q;
  logic [DW-1:0] sc_q;
  logic          dz_q, sat_q;

  // Advance everything whenever the output slot is free or being taken.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      a_in[l] = s_axis_tdata[l*DW +: DW];
      b_in[l] = s_axis_tdata[(l+LANES)*DW +: DW];
    end
  end

  v3au_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid),
    .mode_i  (s_axis_tuser),
    .a_i     (a_in),
    .b_i     (b_in),
    .f_i     (s_axis_tdata[2*LANES*DW +: DW]),
    .vld_o   (fr_vld),
    .item_o  (fr_item),
    .sumsq_o (fr_sumsq)
  );

  v3au_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (fr_vld),
    .item_i  (fr_item),
    .sumsq_i (fr_sumsq),
    .vld_o   (sq_vld),
    .item_o  (sq_item),
    .len_o   (sq_len)
  );

  v3au_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .item_i (sq_item),
    .len_i  (sq_len),
    .vld_o  (dv_vld),
    .item_o (dv_item),
    .len_o  (dv_len),
    .quo_o  (dv_quo),
    .neg_o  (dv_neg)
  );

  // Apply quotient signs and clamp, then pick the result for the mode.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qneg[l] = ~dv_quo[l][DW-1:0] + 1'b1;
      if (!dv_neg[l]) begin
        qsat[l] = (dv_quo[l] > QPOS_MAX);
        qv[l]   = qsat[l] ? WORD_MAX : dv_quo[l][DW-1:0];
      end else begin
        qsat[l] = (dv_quo[l] > QNEG_MAX);
        qv[l]   = qsat[l] ? WORD_MIN : qneg[l];
      end
    end
    rv_d  = dv_item.v;
    sc_d  = dv_item.sc;
    dz_d  = 1'b0;
    sat_d = dv_item.sat;
    unique case (dv_item.mode)
      MODE_ADD, MODE_SUB, MODE_SCALE, MODE_DOT, MODE_CROSS: begin
        rv_d = dv_item.v;
      end
      MODE_DIV: begin
        if (dv_item.f == '0) begin
          // zero divisor: flag it, zero vector, no clamp
          rv_d  = '0;
          dz_d  = 1'b1;
          sat_d = 1'b0;
        end else begin
          rv_d  = qv;
          sat_d = |qsat;
        end
      end
      MODE_LEN: begin
        rv_d  = '0;
        sat_d = dv_len[DW-1];
        sc_d  = dv_len[DW-1] ? WORD_MAX : dv_len;
      end
      MODE_NORM: begin
        // zero length: A itself is zero, so hand back zeros
        if (dv_len == '0) begin
          rv_d  = '0;
          sat_d = 1'b0;
        end else begin
          rv_d  = qv;
          sat_d = |qsat;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rv_q  <= rv_d;
      sc_q  <= sc_d;
      dz_q  <= dz_d;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {sc_q, rv_q[2], rv_q[1], rv_q[0]};
  assign m_axis_tuser  = {sat_q, dz_q};

endmodule
